/* design/hafs_pkg.sv */
// ----------------------------------------------------------------------------
// Handle allocator package
// Request codes and the memory control bundle shared by the allocator blocks.
// ----------------------------------------------------------------------------
package hafs_pkg;

   // Width of the request code field.
   localparam int FUNC_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_QUERY = 2'd2
   } func_type;

   // Controls from the execute stage to the free stack and live mark memories.
   typedef struct packed {
      logic rd_en;
      logic stack_we;
      logic live_we;
      logic live_wdata;
   } mem_ctrl_type;

endpackage

/* design/hafs_store.sv */
// ----------------------------------------------------------------------------
// Handle allocator storage
// Free stack and live mark memories with registered reads. A read that hits
// the location written in the same cycle returns the newly written data.
// ----------------------------------------------------------------------------
module hafs_store
   import hafs_pkg::*;
#(
   parameter int MAX_HANDLES = 1024
) (
   input  logic                                clock,
   input  mem_ctrl_type                        ctrl,
   input  logic [$clog2(MAX_HANDLES)-1:0]      stack_waddr,
   input  logic [$clog2(MAX_HANDLES+1)-1:0]    stack_wdata,
   input  logic [$clog2(MAX_HANDLES)-1:0]      stack_raddr,
   input  logic [$clog2(MAX_HANDLES)-1:0]      live_waddr,
   input  logic [$clog2(MAX_HANDLES)-1:0]      live_raddr,
   output logic [$clog2(MAX_HANDLES+1)-1:0]    stack_rdata,
   output logic                                live_rdata
);

   localparam int HW = $clog2(MAX_HANDLES + 1);

   logic [HW-1:0] stack_mem [MAX_HANDLES];
   logic          live_mem  [MAX_HANDLES];

   logic [HW-1:0] stack_q_ff;
   logic          stack_fwd_ff;
   logic [HW-1:0] stack_fwd_data_ff;
   logic          live_q_ff;
   logic          live_fwd_ff;
   logic          live_fwd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (ctrl.live_we) begin
         live_mem[live_waddr] <= ctrl.live_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         stack_q_ff        <= stack_mem[stack_raddr];
         stack_fwd_ff      <= ctrl.stack_we && (stack_waddr == stack_raddr);
         stack_fwd_data_ff <= stack_wdata;
         live_q_ff         <= live_mem[live_raddr];
         live_fwd_ff       <= ctrl.live_we && (live_waddr == live_raddr);
         live_fwd_data_ff  <= ctrl.live_wdata;
      end
   end

   assign stack_rdata = stack_fwd_ff ? stack_fwd_data_ff : stack_q_ff;
   assign live_rdata  = live_fwd_ff ? live_fwd_data_ff : live_q_ff;

endmodule

/* design/hafs_engine.sv */
// ----------------------------------------------------------------------------
// Handle allocator engine
// Execute stage, issued and free counters, and the result register. Decides
// each request from the prefetched memory data and drives the memory writes.
// ----------------------------------------------------------------------------
module hafs_engine
   import hafs_pkg::*;
#(
   parameter int MAX_HANDLES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  func_type                            req_func,
   input  logic [$clog2(MAX_HANDLES+1)-1:0]    req_handle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [$clog2(MAX_HANDLES+1)-1:0]    rsp_handle,
   output logic                                rsp_ok,
   output mem_ctrl_type                        ctrl,
   output logic [$clog2(MAX_HANDLES)-1:0]      stack_waddr,
   output logic [$clog2(MAX_HANDLES+1)-1:0]    stack_wdata,
   output logic [$clog2(MAX_HANDLES)-1:0]      stack_raddr,
   output logic [$clog2(MAX_HANDLES)-1:0]      live_waddr,
   output logic [$clog2(MAX_HANDLES)-1:0]      live_raddr,
   input  logic [$clog2(MAX_HANDLES+1)-1:0]    stack_rdata,
   input  logic                                live_rdata
);

   localparam int HW = $clog2(MAX_HANDLES + 1);
   localparam int AW = $clog2(MAX_HANDLES);
   localparam logic [HW-1:0] MAX_COUNT = HW'(MAX_HANDLES);

   logic          exe_valid_ff, exe_valid_in;
   func_type      exe_func_ff;
   logic [HW-1:0] exe_handle_ff;
   logic [HW-1:0] issued_count_ff, issued_count_in;
   logic [HW-1:0] free_count_ff, free_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0] rsp_handle_ff;
   logic          rsp_ok_ff;

   logic          advance;
   logic          accept;
   logic          in_range;
   logic          is_live;
   logic [HW-1:0] res_handle;
   logic          res_ok;
   logic [HW-1:0] issued_next;
   logic [HW-1:0] free_next;
   logic [HW-1:0] live_target;
   logic          stack_push;
   logic          live_set;
   logic          live_clear;
   logic [HW-1:0] stack_top;
   logic [HW-1:0] req_index;
   logic [HW-1:0] live_index;

   assign advance   = exe_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !exe_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_range = (exe_handle_ff != '0) && (exe_handle_ff <= issued_count_ff);
   assign is_live  = in_range && live_rdata;

   always_comb begin
      res_handle  = exe_handle_ff;
      res_ok      = 1'b0;
      issued_next = issued_count_ff;
      free_next   = free_count_ff;
      live_target = exe_handle_ff;
      stack_push  = 1'b0;
      live_set    = 1'b0;
      live_clear  = 1'b0;
      case (exe_func_ff)
         FUNC_ALLOC: begin
            res_handle = '0;
            if (free_count_ff != '0) begin
               // Reuse the most recently freed handle.
               res_handle  = stack_rdata;
               res_ok      = 1'b1;
               free_next   = free_count_ff - 1'b1;
               live_target = stack_rdata;
               live_set    = 1'b1;
            end else if (issued_count_ff < MAX_COUNT) begin
               issued_next = issued_count_ff + 1'b1;
               res_handle  = issued_next;
               res_ok      = 1'b1;
               live_target = issued_next;
               live_set    = 1'b1;
            end
         end
         FUNC_FREE: begin
            if (is_live && (free_count_ff < MAX_COUNT)) begin
               res_ok     = 1'b1;
               free_next  = free_count_ff + 1'b1;
               stack_push = 1'b1;
               live_clear = 1'b1;
            end
         end
         FUNC_QUERY: begin
            res_ok = is_live;
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
   end

   assign issued_count_in = advance ? issued_next : issued_count_ff;
   assign free_count_in   = advance ? free_next : free_count_ff;

   // The next request reads the stack top as it stands after the current one.
   assign stack_top   = free_count_in - 1'b1;
   assign req_index   = req_handle - 1'b1;

   assign stack_raddr = stack_top[AW-1:0];
   assign live_raddr  = req_index[AW-1:0];
   assign stack_waddr = free_count_ff[AW-1:0];
   assign stack_wdata = exe_handle_ff;

   assign live_index = live_target - 1'b1;
   assign live_waddr = live_index[AW-1:0];

   always_comb begin
      ctrl.rd_en      = accept;
      ctrl.stack_we   = advance && stack_push;
      ctrl.live_we    = advance && (live_set || live_clear);
      ctrl.live_wdata = live_set;
   end

   assign exe_valid_in = accept || (exe_valid_ff && !advance);

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         issued_count_ff <= '0;
         free_count_ff   <= '0;
      end else begin
         exe_valid_ff    <= exe_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         issued_count_ff <= issued_count_in;
         free_count_ff   <= free_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         exe_func_ff   <= req_func;
         exe_handle_ff <= req_handle;
      end
      if (advance) begin
         rsp_handle_ff <= res_handle;
         rsp_ok_ff     <= res_ok;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_ok     = rsp_ok_ff;

endmodule

/* design/handle_allocator_free_stack.sv */
// A result passes through the execute register into the output register.
// Throughput: one request per cycle while rsp_tready accepts the responses;
// the free stack and live mark memories are read when a request is accepted
// and written when it executes.
// Reset clears the issued and free counters; the memories are not cleared
// and need no clearing pass, so requests are taken right after reset.
// ----------------------------------------------------------------------------
// Handle allocator with free stack
// Allocates, frees and checks one-based handles, reusing freed handles LIFO.
// ----------------------------------------------------------------------------
module handle_allocator_free_stack
   import hafs_pkg::*;
#(
   parameter int MAX_HANDLES = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // func, handle
   input  logic [((FUNC_W+$clog2(MAX_HANDLES+1)+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_handle, ok
   output logic [(($clog2(MAX_HANDLES+1)+1+7)/8)*8-1:0]      rsp_tdata
);

   localparam int HW     = $clog2(MAX_HANDLES + 1);
   localparam int AW     = $clog2(MAX_HANDLES);
   localparam int RSP_DW = ((HW + 1 + 7) / 8) * 8;

   mem_ctrl_type  ctrl;
   logic [AW-1:0] stack_waddr;
   logic [HW-1:0] stack_wdata;
   logic [AW-1:0] stack_raddr;
   logic [AW-1:0] live_waddr;
   logic [AW-1:0] live_raddr;
   logic [HW-1:0] stack_rdata;
   logic          live_rdata;
   logic [HW-1:0] rsp_handle;
   logic          rsp_ok;
   func_type      req_func;
   logic [HW-1:0] req_handle;

   assign req_func   = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_handle = req_tdata[FUNC_W+HW-1:FUNC_W];

   hafs_engine #(
      .MAX_HANDLES(MAX_HANDLES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_func),
      .req_handle (req_handle),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_handle (rsp_handle),
      .rsp_ok     (rsp_ok),
      .ctrl       (ctrl),
      .stack_waddr(stack_waddr),
      .stack_wdata(stack_wdata),
      .stack_raddr(stack_raddr),
      .live_waddr (live_waddr),
      .live_raddr (live_raddr),
      .stack_rdata(stack_rdata),
      .live_rdata (live_rdata)
   );

   hafs_store #(
      .MAX_HANDLES(MAX_HANDLES)
   ) u_store (
      .clock      (clock),
      .ctrl       (ctrl),
      .stack_waddr(stack_waddr),
      .stack_wdata(stack_wdata),
      .stack_raddr(stack_raddr),
      .live_waddr (live_waddr),
      .live_raddr (live_raddr),
      .stack_rdata(stack_rdata),
      .live_rdata (live_rdata)
   );

   assign rsp_tdata = RSP_DW'({rsp_ok, rsp_handle});

endmodule
